// File: rtl/fcc_pkg.sv
// Package for the FAT cluster-chain engine: constants, codes, the config
// struct and the entry decode function. No dependencies.
package fcc_pkg;

  localparam int FCC_TABLE_DEPTH = 4096;
  localparam int CNT_W = 13;
  localparam int CLU_W = 12;

  localparam logic [31:0] END_MARK = 32'hFFFF_FFF8;
  localparam logic [31:0] ERR_MARK = 32'hFFFF_FFFF;
  localparam logic [31:0] MASK16   = 32'h0000_FFFF;
  localparam logic [31:0] MASK28   = 32'h0FFF_FFFF;
  localparam logic [31:0] ZERO_ENT = 32'h0000_0000;
  localparam logic [CNT_W-1:0] FREE_MAX = 13'd8191;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_SPACE = 3'd1;
  localparam logic [2:0] ST_FREE  = 3'd2;
  localparam logic [2:0] ST_LIMIT = 3'd3;
  localparam logic [2:0] ST_INDEX = 3'd4;

  localparam logic [2:0] ACT_LOAD  = 3'd0;
  localparam logic [2:0] ACT_NEXT  = 3'd1;
  localparam logic [2:0] ACT_LEN   = 3'd2;
  localparam logic [2:0] ACT_EXT   = 3'd3;
  localparam logic [2:0] ACT_FREE  = 3'd4;
  localparam logic [2:0] ACT_STATS = 3'd5;
  localparam logic [2:0] ACT_HINTS = 3'd6;

  localparam logic REG_FAT32 = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic             fat32;
    logic [CNT_W-1:0] cluster_count;
  } fcc_cfg_t;

  // Decode a raw entry; every end-of-chain value becomes END_MARK.
  function automatic logic [31:0] fcc_decode(input logic [31:0] raw, input logic fat32);
    logic [31:0] m;
    begin
      if (fat32) begin
        m = raw & MASK28;
        fcc_decode = (raw >= (END_MARK & MASK28)) ? END_MARK : m;
      end else begin
        m = raw & MASK16;
        fcc_decode = (m >= (END_MARK & MASK16)) ? END_MARK : m;
      end
    end
  endfunction

endpackage

// File: rtl/fcc_chan_if.sv
// Valid/ready channel interfaces for the input and result transactions.
// Depends on fcc_pkg.
interface fcc_in_if;
  import fcc_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       action;
  logic [CLU_W-1:0] cluster;
  logic [31:0]      entry_value;
  logic [CLU_W-1:0] cluster_total;
  modport source (output valid, action, cluster, entry_value, cluster_total, input ready);
  modport sink (input valid, action, cluster, entry_value, cluster_total, output ready);
endinterface

interface fcc_out_if;
  import fcc_pkg::*;
  logic             valid;
  logic             ready;
  logic [31:0]      result_value;
  logic [CNT_W-1:0] alloc_count;
  logic [CLU_W-1:0] first_free;
  logic [2:0]       status;
  modport source (output valid, result_value, alloc_count, first_free, status, input ready);
  modport sink (input valid, result_value, alloc_count, first_free, status, output ready);
endinterface

// File: rtl/fcc_table.sv
// Allocation table memory: one write port, one read port, registered read.
// Depends on nothing but its parameters.
module fcc_table #(
  parameter int TABLE_DEPTH = 4096,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: rtl/fcc_apb.sv
// APB-style configuration registers (FAT mode and cluster count).
// Depends on fcc_pkg.
module fcc_apb (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output fcc_pkg::fcc_cfg_t cfg
);
  import fcc_pkg::*;

  logic             fat32_r;
  logic [CNT_W-1:0] count_r;
  logic             wr;

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat32_r <= 1'b1;
      count_r <= 13'd4096;
    end else if (wr) begin
      unique case (paddr[2])
        REG_FAT32: fat32_r <= pwdata[0];
        REG_COUNT: count_r <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FAT32: prdata = {31'd0, fat32_r};
      REG_COUNT: prdata = {19'd0, count_r};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg.fat32         = fat32_r;
  assign cfg.cluster_count = count_r;
endmodule

// File: rtl/fcc_seq.sv
// Sequencer: clearing pass, chain walks, free searches and statistics; each walk,
// search or statistics step is a read of the table followed by an evaluate state. Depends on fcc_pkg.
module fcc_seq #(
  parameter int TABLE_DEPTH = 4096,
  parameter int AW = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fcc_pkg::fcc_cfg_t cfg,
  fcc_in_if.sink            in_ch,
  fcc_out_if.source         out_ch,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [31:0]       mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [31:0]       mem_rdata
);
  import fcc_pkg::*;

  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);
  localparam logic [AW:0] DEPTH_I = (AW+1)'(TABLE_DEPTH);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WRD   = 4'd2;
  localparam logic [3:0] S_WEV   = 4'd3;
  localparam logic [3:0] S_AINIT = 4'd4;
  localparam logic [3:0] S_ARD   = 4'd5;
  localparam logic [3:0] S_AEV   = 4'd6;
  localparam logic [3:0] S_LINK  = 4'd7;
  localparam logic [3:0] S_SRD   = 4'd8;
  localparam logic [3:0] S_SEV   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]       state_r, state_nxt;
  logic [2:0]       act_r, act_nxt;
  logic [CLU_W-1:0] tot_r, tot_nxt;
  logic [AW-1:0]    cur_r, cur_nxt;
  logic [31:0]      res_r, res_nxt;
  logic [2:0]       st_r, st_nxt;
  logic [CLU_W-1:0] ffree_r, ffree_nxt;
  logic [AW:0]      i_r, i_nxt;
  logic [CNT_W-1:0] c_r, c_nxt, end_r, end_nxt, start_r, start_nxt;
  logic             wrap_r, wrap_nxt;
  logic [CLU_W-1:0] ai_r, ai_nxt;
  logic [CLU_W-1:0] hint_r, hint_nxt;
  logic [CNT_W-1:0] ftot_r, ftot_nxt;
  logic             ov_r, ov_nxt;
  logic [31:0]      o_res_r, o_res_nxt;
  logic [CNT_W-1:0] o_acnt_r, o_acnt_nxt;
  logic [CLU_W-1:0] o_ff_r, o_ff_nxt;
  logic [2:0]       o_st_r, o_st_nxt;

  logic [31:0]      lim32, d, cl32;
  logic [CNT_W-1:0] lim, start_c, tot_eff;
  logic             hit;

  assign lim32   = (32'(cfg.cluster_count) < DEPTH32) ? 32'(cfg.cluster_count) : DEPTH32;
  assign lim     = lim32[CNT_W-1:0];
  assign d       = fcc_decode(mem_rdata, cfg.fat32);
  assign hit     = (d == ZERO_ENT);
  assign cl32    = 32'(in_ch.cluster);
  assign start_c = 13'(hint_r) + 13'd1;
  assign tot_eff = (tot_r == '0) ? 13'd1 : 13'(tot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      i_r     <= '0;
      hint_r  <= 12'd1;
      ftot_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      hint_r  <= hint_nxt;
      ftot_r  <= ftot_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    tot_r    <= tot_nxt;
    cur_r    <= cur_nxt;
    res_r    <= res_nxt;
    st_r     <= st_nxt;
    ffree_r  <= ffree_nxt;
    c_r      <= c_nxt;
    end_r    <= end_nxt;
    start_r  <= start_nxt;
    wrap_r   <= wrap_nxt;
    ai_r     <= ai_nxt;
    o_res_r  <= o_res_nxt;
    o_acnt_r <= o_acnt_nxt;
    o_ff_r   <= o_ff_nxt;
    o_st_r   <= o_st_nxt;
  end

  always_comb begin
    state_nxt = state_r; act_nxt = act_r; tot_nxt = tot_r; cur_nxt = cur_r;
    res_nxt = res_r; st_nxt = st_r; ffree_nxt = ffree_r; i_nxt = i_r;
    c_nxt = c_r; end_nxt = end_r; start_nxt = start_r; wrap_nxt = wrap_r;
    ai_nxt = ai_r; hint_nxt = hint_r; ftot_nxt = ftot_r;
    ov_nxt = ov_r & ~out_ch.ready;
    o_res_nxt = o_res_r; o_acnt_nxt = o_acnt_r; o_ff_nxt = o_ff_r; o_st_nxt = o_st_r;
    mem_we = 1'b0; mem_waddr = cur_r; mem_wdata = ZERO_ENT;
    mem_re = 1'b0; mem_raddr = cur_r;
    in_ch.ready = (state_r == S_IDLE);

    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = i_r[AW-1:0];
        i_nxt     = i_r + 1'b1;
        if (i_r == DEPTH_I - 1'b1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          act_nxt = in_ch.action; tot_nxt = in_ch.cluster_total;
          res_nxt = '0; st_nxt = ST_OK; ffree_nxt = '0; i_nxt = '0; ai_nxt = '0;
          cur_nxt = AW'(in_ch.cluster);
          state_nxt = S_DONE;
          unique case (in_ch.action)
            ACT_LOAD: begin
              if (cl32 >= DEPTH32) st_nxt = ST_INDEX;
              else begin
                mem_we = 1'b1; mem_waddr = AW'(in_ch.cluster); mem_wdata = in_ch.entry_value;
              end
            end
            ACT_NEXT: begin
              if (cl32 >= DEPTH32) begin
                res_nxt = ERR_MARK; st_nxt = ST_INDEX;
              end else state_nxt = S_WRD;
            end
            ACT_LEN, ACT_FREE, ACT_EXT: begin
              if (in_ch.cluster == '0) begin
                if (in_ch.action == ACT_EXT) begin
                  cur_nxt = '0; state_nxt = S_AINIT;
                end
              end else if (cl32 >= DEPTH32) st_nxt = ST_INDEX;
              else state_nxt = S_WRD;
            end
            ACT_STATS: begin
              c_nxt = 13'd2; state_nxt = S_SRD;
            end
            ACT_HINTS: begin
              hint_nxt = in_ch.cluster;
              ftot_nxt = (in_ch.entry_value > 32'(FREE_MAX)) ? FREE_MAX
                                                            : in_ch.entry_value[CNT_W-1:0];
            end
            default: ;
          endcase
        end
      end
      S_WRD: begin
        mem_re = 1'b1; mem_raddr = cur_r; state_nxt = S_WEV;
      end
      S_WEV: begin
        state_nxt = S_DONE;
        if (act_r == ACT_NEXT) begin
          res_nxt = hit ? ERR_MARK : d;
          st_nxt  = hit ? ST_FREE : ST_OK;
        end else if (hit) begin
          // A chain length counts the free entry it stopped on.
          st_nxt = ST_FREE;
          if (act_r == ACT_LEN) res_nxt = res_r + 32'd1;
        end else begin
          if (act_r == ACT_LEN) res_nxt = res_r + 32'd1;
          if (act_r == ACT_FREE) begin
            mem_we = 1'b1; mem_waddr = cur_r; mem_wdata = ZERO_ENT;
            res_nxt = res_r + 32'd1;
            if (ftot_r < FREE_MAX) ftot_nxt = ftot_r + 1'b1;
          end
          priority if (d >= END_MARK) begin
            st_nxt = ST_OK;
            if (act_r == ACT_EXT) state_nxt = S_AINIT;
          end else if (d >= DEPTH32) st_nxt = ST_INDEX;
          else begin
            cur_nxt = AW'(d);
            i_nxt   = i_r + 1'b1;
            if (i_r + 1'b1 == DEPTH_I) st_nxt = ST_LIMIT;
            else state_nxt = S_WRD;
          end
        end
      end
      S_AINIT: begin
        start_nxt = start_c;
        c_nxt     = (start_c < 13'd2) ? 13'd2 : start_c;
        end_nxt   = lim;
        wrap_nxt  = 1'b0;
        state_nxt = S_ARD;
      end
      S_ARD: begin
        if (c_r >= end_r) begin
          if (!wrap_r) begin
            c_nxt = 13'd2; end_nxt = (start_r < lim) ? start_r : lim; wrap_nxt = 1'b1;
          end else begin
            st_nxt = ST_SPACE; state_nxt = S_DONE;
          end
        end else begin
          mem_re = 1'b1; mem_raddr = AW'(c_r); state_nxt = S_AEV;
        end
      end
      S_AEV: begin
        if (hit) begin
          mem_we = 1'b1; mem_waddr = AW'(c_r); mem_wdata = ERR_MARK;
          hint_nxt = c_r[CLU_W-1:0];
          if (ftot_r != '0) ftot_nxt = ftot_r - 1'b1;
          if (ai_r == '0) res_nxt = 32'(c_r);
          if (cur_r != '0) state_nxt = S_LINK;
          else begin
            cur_nxt = AW'(c_r); ai_nxt = ai_r + 1'b1;
            state_nxt = (13'(ai_r) + 13'd1 == tot_eff) ? S_DONE : S_AINIT;
          end
        end else begin
          c_nxt = c_r + 1'b1; state_nxt = S_ARD;
        end
      end
      S_LINK: begin
        mem_we = 1'b1; mem_waddr = cur_r; mem_wdata = 32'(c_r);
        cur_nxt = AW'(c_r); ai_nxt = ai_r + 1'b1;
        state_nxt = (13'(ai_r) + 13'd1 == tot_eff) ? S_DONE : S_AINIT;
      end
      S_SRD: begin
        if (c_r >= lim) state_nxt = S_DONE;
        else begin
          mem_re = 1'b1; mem_raddr = AW'(c_r); state_nxt = S_SEV;
        end
      end
      S_SEV: begin
        if (hit) begin
          if (res_r == '0) ffree_nxt = c_r[CLU_W-1:0];
          res_nxt = res_r + 32'd1;
        end
        c_nxt = c_r + 1'b1; state_nxt = S_SRD;
      end
      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt     = 1'b1;
          o_res_nxt  = res_r;
          o_st_nxt   = st_r;
          o_ff_nxt   = (act_r == ACT_STATS) ? ffree_r : '0;
          o_acnt_nxt = (act_r == ACT_STATS) ? cfg.cluster_count - res_r[CNT_W-1:0] : '0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.result_value = o_res_r;
  assign out_ch.alloc_count  = o_acnt_r;
  assign out_ch.first_free   = o_ff_r;
  assign out_ch.status       = o_st_r;
endmodule

// File: rtl/fat_cluster_chain_engine.sv
// Top level of the FAT cluster-chain engine: configuration registers,
// sequencer and table memory. Depends on fcc_pkg, fcc_chan_if, fcc_apb, fcc_seq and fcc_table.
//
//   Channel  Direction  Handshake        Carries
//   in_ch    sink       valid/ready      action, cluster, entry_value, cluster_total
//   out_ch   source     valid/ready      result_value, alloc_count, first_free, status
//   cfg_*    slave      psel/penable     fat32_mode (0x0), cluster_count (0x4)
//
// Every table access is a read of the memory followed by an evaluate state,
// so a walk reads and evaluates each entry before registering its result; a
// next is one read and evaluate, and a load, hint or unused-action transaction
// goes straight to its result. Extend adds a set-up state per allocated
// cluster, a read and evaluate per entry searched and a link state; statistics
// read and evaluate every cluster from 2 up to the limit. One transaction is in
// work at a time. After reset the table is cleared one entry per cycle, all
// TABLE_DEPTH entries, while in_ch.ready stays low. A finished result waits in
// the output register and the engine holds the next result until it is taken.
module fat_cluster_chain_engine #(
  parameter int TABLE_DEPTH = fcc_pkg::FCC_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  fcc_in_if.sink      in_ch,
  fcc_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fcc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  fcc_cfg_t      cfg;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;

  // Configuration must be written only while the engine is idle; the block itself does not enforce it.
  fcc_apb u_apb (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg)
  );

  fcc_seq #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_seq (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
    .mem_re(mem_re), .mem_raddr(mem_raddr), .mem_rdata(mem_rdata)
  );

  fcc_table #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );
endmodule
